### hw/rtl/wrms_pkg.sv
// Shared types and register map for the weighted RMS fit error block.
package wrms_pkg;

	localparam logic [1:0] REG_POINTS = 2'd0;
	localparam logic [1:0] REG_FLOWS  = 2'd1;
	localparam logic [1:0] REG_ENABLE = 2'd2;

	typedef struct packed {
		logic        flow_en;
		logic [63:0] flow_sum;
		logic [23:0] flow_div;
		logic [4:0]  flow_num;
		logic        flow_sat;
		logic        tot_en;
		logic [63:0] blk_sum;
		logic [23:0] scale;
		logic        blk_sat;
	} job_t;

endpackage

### hw/rtl/wrms_front.sv
// Front end: accepts trace points, squares weighted error, accumulates flow and block sums.
module wrms_front #(
	parameter int MAX_POINTS = 256,
	parameter int MAX_FLOWS  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [63:0]        s_tdata,
	input  logic [8:0]         points_cfg,
	input  logic [5:0]         flows_cfg,
	input  logic               flow_en_cfg,
	input  logic               q_full,
	output logic               push,
	output wrms_pkg::job_t     push_job
);
	import wrms_pkg::*;

	localparam int PW = $clog2(MAX_POINTS + 1);
	localparam int FW = $clog2(MAX_FLOWS + 1);

	logic          v_s1, v_s2, v_s3;
	logic [16:0]   mag_s1;
	logic [15:0]   w_s1, scale_s1, scale_s2, scale_s3;
	logic [31:0]   e_s2;
	logic [63:0]   sq_s3;
	logic [PW-1:0] npts, pc_q, pc_nx;
	logic [FW-1:0] nflows, fc_q, fc_nx;
	logic [63:0]   fsum_q, bsum_q, fsum_nx, bsum_nx;
	logic [23:0]   ssum_q, ssum_nx;
	logic          fsat_q, bsat_q, fsat_nx, bsat_nx;
	logic [64:0]   fadd, badd;
	logic signed [16:0] diff;
	logic          flow_end, blk_end;

	always_comb begin
		if (points_cfg == 9'd0) begin
			npts = PW'(1);
		end else if (32'(points_cfg) > 32'(MAX_POINTS)) begin
			npts = PW'(MAX_POINTS);
		end else begin
			npts = PW'(points_cfg);
		end
		if (flows_cfg == 6'd0) begin
			nflows = FW'(1);
		end else if (32'(flows_cfg) > 32'(MAX_FLOWS)) begin
			nflows = FW'(MAX_FLOWS);
		end else begin
			nflows = FW'(flows_cfg);
		end
	end

	assign s_tready = !(v_s1 || v_s2 || v_s3) && !q_full;
	assign diff = $signed({s_tdata[15], s_tdata[15:0]}) - $signed({s_tdata[31], s_tdata[31:16]});

	assign fadd     = {1'b0, fsum_q} + {1'b0, sq_s3};
	assign badd     = {1'b0, bsum_q} + {1'b0, sq_s3};
	assign fsum_nx  = fadd[64] ? '1 : fadd[63:0];
	assign bsum_nx  = badd[64] ? '1 : badd[63:0];
	assign fsat_nx  = fsat_q | fadd[64];
	assign bsat_nx  = bsat_q | badd[64];
	assign ssum_nx  = (pc_q == '0) ? ssum_q + 24'(scale_s3) : ssum_q;
	assign pc_nx    = pc_q + PW'(1);
	assign fc_nx    = fc_q + FW'(1);
	assign flow_end = v_s3 && (pc_nx >= npts);
	assign blk_end  = flow_end && (fc_nx >= nflows);
	assign push     = flow_end && (flow_en_cfg || blk_end);

	always_comb begin
		push_job.flow_en  = flow_en_cfg;
		push_job.flow_sum = fsum_nx;
		push_job.flow_div = 24'(npts);
		push_job.flow_num = 5'(fc_q);
		push_job.flow_sat = fsat_nx;
		push_job.tot_en   = blk_end;
		push_job.blk_sum  = bsum_nx;
		push_job.scale    = ssum_nx;
		push_job.blk_sat  = bsat_nx;
	end

	always_ff @(posedge clk) begin
		mag_s1   <= diff[16] ? 17'(-diff) : 17'(diff);
		w_s1     <= s_tdata[47:32];
		scale_s1 <= s_tdata[63:48];
		e_s2     <= 32'(mag_s1 * w_s1);
		scale_s2 <= scale_s1;
		sq_s3    <= e_s2 * e_s2;
		scale_s3 <= scale_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			pc_q   <= '0;
			fc_q   <= '0;
			fsum_q <= '0;
			bsum_q <= '0;
			ssum_q <= '0;
			fsat_q <= 1'b0;
			bsat_q <= 1'b0;
		end else begin
			v_s1 <= s_tvalid && s_tready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				if (flow_end) begin
					pc_q   <= '0;
					fsum_q <= '0;
					fsat_q <= 1'b0;
					if (blk_end) begin
						fc_q   <= '0;
						bsum_q <= '0;
						ssum_q <= '0;
						bsat_q <= 1'b0;
					end else begin
						fc_q   <= fc_nx;
						bsum_q <= bsum_nx;
						ssum_q <= ssum_nx;
						bsat_q <= bsat_nx;
					end
				end else begin
					pc_q   <= pc_nx;
					fsum_q <= fsum_nx;
					fsat_q <= fsat_nx;
					bsum_q <= bsum_nx;
					ssum_q <= ssum_nx;
					bsat_q <= bsat_nx;
				end
			end
		end
	end

endmodule

### hw/rtl/wrms_jobq.sv
// Two-entry job queue between front end and back end.
module wrms_jobq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wrms_pkg::job_t  push_job,
	input  logic            pop,
	output wrms_pkg::job_t  head,
	output logic            empty,
	output logic            full
);
	import wrms_pkg::*;

	job_t       mem [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("job pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("job popped from empty queue");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && !full) |=> !empty)
		else $error("queue count lost a push");
`endif

endmodule

### hw/rtl/wrms_back.sv
// Back end: serial divider and square root producing result transactions.
module wrms_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  wrms_pkg::job_t head,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [39:0]    m_tdata,
	output logic           m_tuser,
	output logic           m_tlast
);
	import wrms_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_DIV, B_SQRT, B_OUT} bstate_t;

	bstate_t     st_q;
	logic        tot_q;
	logic [71:0] dvd_q, dvd_nx;
	logic [23:0] div_q, rem_q, rem_nx;
	logic [24:0] rem2;
	logic [6:0]  cnt_q;
	logic [63:0] x_q;
	logic [34:0] srem_q, stmp, strial;
	logic [31:0] root_q, root_nx;
	logic [34:0] srem_nx;
	logic [31:0] rms_q;
	logic [4:0]  fnum_q;
	logic        zerr_q, sat_q, last_q;

	assign rem2 = {rem_q, dvd_q[71]};
	always_comb begin
		if (rem2 >= {1'b0, div_q}) begin
			rem_nx = 24'(rem2 - {1'b0, div_q});
			dvd_nx = {dvd_q[70:0], 1'b1};
		end else begin
			rem_nx = rem2[23:0];
			dvd_nx = {dvd_q[70:0], 1'b0};
		end
	end

	assign stmp   = {srem_q[32:0], x_q[63:62]};
	assign strial = {1'b0, root_q, 2'b01};
	always_comb begin
		if (stmp >= strial) begin
			srem_nx = stmp - strial;
			root_nx = {root_q[30:0], 1'b1};
		end else begin
			srem_nx = stmp;
			root_nx = {root_q[30:0], 1'b0};
		end
	end

	assign m_tvalid = (st_q == B_OUT);
	assign m_tdata  = {1'b0, sat_q, zerr_q, fnum_q, rms_q};
	assign m_tuser  = tot_q;
	assign m_tlast  = last_q;
	assign pop      = m_tvalid && m_tready && (tot_q || !head.tot_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= B_IDLE;
			tot_q  <= 1'b0;
			dvd_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			x_q    <= '0;
			srem_q <= '0;
			root_q <= '0;
			rms_q  <= '0;
			fnum_q <= '0;
			zerr_q <= 1'b0;
			sat_q  <= 1'b0;
			last_q <= 1'b0;
		end else begin
			case (st_q)
				B_IDLE: begin
					if (!q_empty) begin
						rem_q <= '0;
						cnt_q <= '0;
						if (head.flow_en) begin
							tot_q  <= 1'b0;
							dvd_q  <= {8'd0, head.flow_sum};
							div_q  <= head.flow_div;
							fnum_q <= head.flow_num;
							sat_q  <= head.flow_sat;
							zerr_q <= 1'b0;
							last_q <= !head.tot_en;
							st_q   <= B_DIV;
						end else begin
							tot_q  <= 1'b1;
							dvd_q  <= {head.blk_sum, 8'd0};
							div_q  <= head.scale;
							fnum_q <= '0;
							sat_q  <= head.blk_sat;
							last_q <= 1'b1;
							zerr_q <= (head.scale == '0);
							rms_q  <= '0;
							st_q   <= (head.scale == '0) ? B_OUT : B_DIV;
						end
					end
				end
				B_DIV: begin
					dvd_q <= dvd_nx;
					rem_q <= rem_nx;
					if (cnt_q == 7'd71) begin
						cnt_q <= '0;
						if (dvd_nx[71:64] != 8'd0) begin
							rms_q <= '1;
							st_q  <= B_OUT;
						end else begin
							x_q    <= dvd_nx[63:0];
							srem_q <= '0;
							root_q <= '0;
							st_q   <= B_SQRT;
						end
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				B_SQRT: begin
					srem_q <= srem_nx;
					root_q <= root_nx;
					x_q    <= {x_q[61:0], 2'b00};
					cnt_q  <= cnt_q + 7'd1;
					if (cnt_q == 7'd31) begin
						rms_q <= root_nx;
						st_q  <= B_OUT;
					end
				end
				B_OUT: begin
					if (m_tready) begin
						if (!tot_q && head.tot_en) begin
							tot_q  <= 1'b1;
							dvd_q  <= {head.blk_sum, 8'd0};
							div_q  <= head.scale;
							rem_q  <= '0;
							cnt_q  <= '0;
							fnum_q <= '0;
							sat_q  <= head.blk_sat;
							last_q <= 1'b1;
							zerr_q <= (head.scale == '0);
							rms_q  <= '0;
							st_q   <= (head.scale == '0) ? B_OUT : B_DIV;
						end else begin
							st_q <= B_IDLE;
						end
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_flow_no_zerr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> !m_tdata[37])
		else $error("per-flow result flagged zero scale");
	a_total_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata[36:32] == 5'd0))
		else $error("total result not last or nonzero flow number");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");
`endif

endmodule

### hw/rtl/weighted_rms_fit_error_top.sv
// Top level of the weighted RMS fit error block: config registers and front/back wiring.
//
// Input stream s_*: one trace point per transaction, tdata = observed_sample,
// fitted_sample, emphasis_weight, flow_scale (16 bits each, lowest first).
// Output stream m_*: one result per transaction; tuser marks the block total,
// tlast marks the final result caused by one input point.
// APB port: points_per_flow at 0x0, flows_per_block at 0x4, per_flow_enable
// at 0x8; write only while the block is idle.
// Front end takes a new point only after the previous one has passed its three
// pipeline stages (difference, weight multiply, square) and the accumulate. A flow
// end pushes a job into a two-entry queue when per-flow results are enabled or the
// block ends; the back end runs a bit-serial divider and a bit-serial square root
// per result (a zero-scale total skips both).
// Reset clears all counts and sums and sets registers to 1, 1, 1.
// When the receiver stalls, the result holds; the queue fills and then
// s_tready drops until a job retires.
module weighted_rms_fit_error_top #(
	parameter int MAX_POINTS = 256,
	parameter int MAX_FLOWS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // observed, fitted, weight, scale
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // rms_value, flow_number, scale_zero_error, accum_saturated, pad
	output logic        m_tuser,   // is_total
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import wrms_pkg::*;

	logic [8:0] pts_q;
	logic [5:0] flw_q;
	logic       en_q;
	logic       push, pop, q_empty, q_full;
	job_t       push_job, head;

	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			REG_POINTS: prdata = {23'd0, pts_q};
			REG_FLOWS:  prdata = {26'd0, flw_q};
			REG_ENABLE: prdata = {31'd0, en_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= 9'd1;
			flw_q <= 6'd1;
			en_q  <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_POINTS: pts_q <= pwdata[8:0];
				REG_FLOWS:  flw_q <= pwdata[5:0];
				REG_ENABLE: en_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	wrms_front #(.MAX_POINTS(MAX_POINTS), .MAX_FLOWS(MAX_FLOWS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.points_cfg(pts_q), .flows_cfg(flw_q), .flow_en_cfg(en_q),
		.q_full(q_full), .push(push), .push_job(push_job)
	);

	wrms_jobq u_jobq (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job),
		.pop(pop), .head(head), .empty(q_empty), .full(q_full)
	);

	wrms_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .head(head), .pop(pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

endmodule
